[rtl/bgls_pkg.sv]
package bgls_pkg;

   localparam int unsigned CFG_W      = 12;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned STEP_W     = 3;
   localparam int unsigned STEP_COUNT = 8;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_COUNT - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_INTERVAL = CSR_IDX_W'(3);

   localparam logic [CFG_W-1:0] LONG_PRESS_RST    = CFG_W'(2000);
   localparam logic [CFG_W-1:0] DEBOUNCE_RST      = CFG_W'(20);
   localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST  = CFG_W'(100);
   localparam logic [CFG_W-1:0] AUTO_INTERVAL_RST = CFG_W'(200);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HELD   = 2'd1,
      PH_WINDOW = 2'd2,
      PH_HELD2  = 2'd3
   } phase_type;

   function automatic logic [STEP_W-1:0] step_next(input logic [STEP_W-1:0] idx,
                                                   input logic up);
      logic [STEP_W-1:0] res;
      if (up) begin
         res = (idx >= STEP_LAST) ? '0 : idx + STEP_W'(1);
      end else begin
         res = (idx == '0) ? STEP_LAST : idx - STEP_W'(1);
      end
      return res;
   endfunction

   function automatic logic [STEP_W-1:0] bit_rev(input logic [STEP_W-1:0] idx);
      logic [STEP_W-1:0] res;
      for (int i = 0; i < int'(STEP_W); i++) begin
         res[i] = idx[STEP_W-1-i];
      end
      return res;
   endfunction

endpackage

[rtl/button_gesture_led_stepper_core.sv]
// The rsp_ result of a req_ transfer becomes valid in the cycle after the transfer.
// Throughput: one tick per cycle; req_ready drops only while a result waits
// in the output register and rsp_ready is low.
// Reset (synchronous, active high): idle phase, counter and step index zero,
// manual mode, counting up, registers at their defaults, no result pending.
module button_gesture_led_stepper_core #(
   parameter int unsigned TICK_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_button_down,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bgls_pkg::STEP_W-1:0]        rsp_led_rgb,
   output logic                               rsp_auto_on,
   output logic                               rsp_count_up,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bgls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bgls_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int unsigned CMP_W =
      (TICK_BITS > bgls_pkg::CFG_W) ? TICK_BITS : bgls_pkg::CFG_W;

   logic [bgls_pkg::CFG_W-1:0] long_press_ff, debounce_ff, double_click_ff, auto_interval_ff;

   bgls_pkg::phase_type         phase_ff, phase_in;
   logic [TICK_BITS-1:0]        tick_ff, tick_in, tick_inc;
   logic [bgls_pkg::STEP_W-1:0] idx_ff, idx_in;
   logic                        auto_ff, auto_in;
   logic                        up_ff, up_in;

   logic                        rsp_valid_ff;
   logic [bgls_pkg::STEP_W-1:0] led_ff;
   logic                        auto_out_ff, up_out_ff;

   logic                        req_fire;
   logic [CMP_W-1:0]            tick_x, tick_inc_x;
   logic [CMP_W-1:0]            long_x, deb_x, dc_x, ai_x;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign tick_inc   = (tick_ff == '1) ? tick_ff : tick_ff + TICK_BITS'(1);
   assign tick_x     = CMP_W'(tick_ff);
   assign tick_inc_x = CMP_W'(tick_inc);
   assign long_x     = CMP_W'(long_press_ff);
   assign deb_x      = CMP_W'(debounce_ff);
   assign dc_x       = CMP_W'(double_click_ff);
   assign ai_x       = CMP_W'(auto_interval_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff    <= bgls_pkg::LONG_PRESS_RST;
         debounce_ff      <= bgls_pkg::DEBOUNCE_RST;
         double_click_ff  <= bgls_pkg::DOUBLE_CLICK_RST;
         auto_interval_ff <= bgls_pkg::AUTO_INTERVAL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bgls_pkg::CSR_LONG_PRESS:    long_press_ff    <= csr_wdata;
            bgls_pkg::CSR_DEBOUNCE:      debounce_ff      <= csr_wdata;
            bgls_pkg::CSR_DOUBLE_CLICK:  double_click_ff  <= csr_wdata;
            bgls_pkg::CSR_AUTO_INTERVAL: auto_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      idx_in   = idx_ff;
      auto_in  = auto_ff;
      up_in    = up_ff;
      if (req_fire) begin
         case (phase_ff)
            bgls_pkg::PH_IDLE: begin
               if (req_button_down) begin
                  phase_in = bgls_pkg::PH_HELD;
                  tick_in  = '0;
               end else begin
                  tick_in = tick_inc;
                  if (auto_ff && (tick_inc_x > ai_x)) begin
                     tick_in = '0;
                     idx_in  = bgls_pkg::step_next(idx_ff, up_ff);
                  end
               end
            end
            bgls_pkg::PH_HELD: begin
               if (req_button_down) begin
                  tick_in = tick_inc;
               end else if (tick_x > long_x) begin
                  up_in    = !up_ff;
                  phase_in = bgls_pkg::PH_IDLE;
               end else if (tick_x > deb_x) begin
                  if (auto_ff) begin
                     auto_in  = 1'b0;
                     phase_in = bgls_pkg::PH_IDLE;
                  end else begin
                     tick_in  = '0;
                     phase_in = bgls_pkg::PH_WINDOW;
                  end
               end else begin
                  phase_in = bgls_pkg::PH_IDLE;
               end
            end
            bgls_pkg::PH_WINDOW: begin
               tick_in = tick_inc;
               if (tick_inc_x >= dc_x) begin
                  idx_in   = bgls_pkg::step_next(idx_ff, up_ff);
                  phase_in = bgls_pkg::PH_IDLE;
               end else if (req_button_down && (tick_inc_x > deb_x)) begin
                  phase_in = bgls_pkg::PH_HELD2;
               end
            end
            bgls_pkg::PH_HELD2: begin
               tick_in = tick_inc;
               if (!req_button_down) begin
                  auto_in  = !auto_ff;
                  phase_in = bgls_pkg::PH_IDLE;
               end
            end
            default: phase_in = bgls_pkg::PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bgls_pkg::PH_IDLE;
         tick_ff  <= '0;
         idx_ff   <= '0;
         auto_ff  <= 1'b0;
         up_ff    <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         idx_ff   <= idx_in;
         auto_ff  <= auto_in;
         up_ff    <= up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         led_ff      <= bgls_pkg::bit_rev(idx_in);
         auto_out_ff <= auto_in;
         up_out_ff   <= up_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_led_rgb  = led_ff;
   assign rsp_auto_on  = auto_out_ff;
   assign rsp_count_up = up_out_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result pending after reset");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("transfer without result");

   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(idx_ff) && $stable(phase_ff))
      else $error("state moved without transfer");

   a_dir_flip: assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff != bgls_pkg::PH_HELD) |=> $stable(up_ff))
      else $error("direction flipped outside held phase");
`endif

endmodule
